// File: hdl/lgnc_pkg.sv
// Shared types and codes for the life grid neighbor census block.
package lgnc_pkg;

  // Operation codes carried by the kind field of an input word.
  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CENSUS = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_WRAP = 2'd2;

  localparam int DIM_W   = 7;
  localparam int COUNT_W = 4;

  // Which of the neighbor rows and columns take part in a census.
  typedef struct packed {
    logic above;
    logic below;
    logic left;
    logic right;
  } nbr_ok_t;

endpackage

// File: hdl/life_grid_neighbor_census.sv
// Top level of the life grid neighbor census block.
// Usage: an input word (kind, row, col) enters on in_valid/in_ready and
// every word gives exactly one result word on out_valid/out_ready.
// kind sets a cell live or dead, reads it, or counts its eight neighbors;
// a cell outside the area in use changes nothing and reports out_of_range.
// The grid is held in three identical memory copies that all take every
// write, so the rows above, at and below the center are read at once.
// Each word passes the memory read register, then the result register, on
// its way to out_valid. One word is taken per cycle when the receiver keeps
// out_ready high.
// The configuration port (cfg_valid, cfg_index, cfg_data) is always ready; the user
// must write it only while the block is idle, and the block itself does not enforce this.
// After reset the block sweeps the grid clear, one row per cycle, through
// all MAX_ROWS rows; in_ready stays low during that pass.
// When the receiver stalls, the result register holds and the pipeline
// fills; in_ready drops once both stages are full.
module life_grid_neighbor_census #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        cell_alive,
  output logic [3:0]  neighbor_count,
  output logic        out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int DW = lgnc_pkg::DIM_W;

  logic [DW-1:0] rows_in_use, cols_in_use;
  logic          wrap_edges;
  logic [DW-1:0] eff_rows, eff_cols;

  logic          clearing;
  logic [RW-1:0] clr_row;

  logic          accept, advance, oor, wr_en;
  logic [DW-1:0] row7, col7, up7, dn7, lf7, rt7;
  logic          up_ok, dn_ok, lf_ok, rt_ok;
  logic [RW-1:0] rd_up, rd_mid, rd_dn;

  logic                  s1_valid;
  lgnc_pkg::kind_t       s1_kind;
  logic                  s1_oor;
  logic [CW-1:0]         s1_col, s1_left, s1_right;
  lgnc_pkg::nbr_ok_t     s1_ok;
  logic [MAX_COLS-1:0]   word_up, word_mid, word_dn;
  logic [lgnc_pkg::COUNT_W-1:0] census_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= DW'(64);
      cols_in_use <= DW'(64);
      wrap_edges  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lgnc_pkg::REG_ROWS: rows_in_use <= cfg_data;
        lgnc_pkg::REG_COLS: cols_in_use <= cfg_data;
        lgnc_pkg::REG_WRAP: wrap_edges  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A zero size counts as one, and a size past the grid counts as the grid.
  always_comb begin
    eff_rows = rows_in_use;
    if (rows_in_use == '0) begin
      eff_rows = DW'(1);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      eff_rows = DW'(MAX_ROWS);
    end
    eff_cols = cols_in_use;
    if (cols_in_use == '0) begin
      eff_cols = DW'(1);
    end else if (int'(cols_in_use) > MAX_COLS) begin
      eff_cols = DW'(MAX_COLS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      if (clr_row == RW'(MAX_ROWS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = !clearing && (!s1_valid || advance);
  assign accept   = in_valid && in_ready;

  // Neighbor coordinates; at an edge they wrap or drop out of the census.
  always_comb begin
    row7  = {1'b0, row};
    col7  = {1'b0, col};
    oor   = (row7 >= eff_rows) || (col7 >= eff_cols);
    wr_en = accept && !oor && (kind == lgnc_pkg::KIND_SET || kind == lgnc_pkg::KIND_CLEAR);

    up_ok = (row7 != '0) || wrap_edges;
    up7   = (row7 == '0) ? eff_rows - 1'b1 : row7 - 1'b1;
    dn_ok = (row7 != eff_rows - 1'b1) || wrap_edges;
    dn7   = (row7 == eff_rows - 1'b1) ? '0 : row7 + 1'b1;
    lf_ok = (col7 != '0) || wrap_edges;
    lf7   = (col7 == '0) ? eff_cols - 1'b1 : col7 - 1'b1;
    rt_ok = (col7 != eff_cols - 1'b1) || wrap_edges;
    rt7   = (col7 == eff_cols - 1'b1) ? '0 : col7 + 1'b1;

    rd_mid = oor ? '0 : RW'(row7);
    rd_up  = (oor || !up_ok) ? '0 : RW'(up7);
    rd_dn  = (oor || !dn_ok) ? '0 : RW'(dn7);
  end

  lgnc_row_mem #(.ROWS(MAX_ROWS), .COLS(MAX_COLS)) u_mem_up (
    .clk, .clr_en(clearing), .clr_row, .wr_en, .wr_row(RW'(row7)), .wr_col(CW'(col7)),
    .wr_bit(kind == lgnc_pkg::KIND_SET), .rd_en(accept), .rd_row(rd_up), .rd_data(word_up)
  );

  lgnc_row_mem #(.ROWS(MAX_ROWS), .COLS(MAX_COLS)) u_mem_mid (
    .clk, .clr_en(clearing), .clr_row, .wr_en, .wr_row(RW'(row7)), .wr_col(CW'(col7)),
    .wr_bit(kind == lgnc_pkg::KIND_SET), .rd_en(accept), .rd_row(rd_mid), .rd_data(word_mid)
  );

  lgnc_row_mem #(.ROWS(MAX_ROWS), .COLS(MAX_COLS)) u_mem_dn (
    .clk, .clr_en(clearing), .clr_row, .wr_en, .wr_row(RW'(row7)), .wr_col(CW'(col7)),
    .wr_bit(kind == lgnc_pkg::KIND_SET), .rd_en(accept), .rd_row(rd_dn), .rd_data(word_dn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= lgnc_pkg::kind_t'(kind);
      s1_oor   <= oor;
      s1_col   <= oor ? '0 : CW'(col7);
      s1_left  <= (oor || !lf_ok) ? '0 : CW'(lf7);
      s1_right <= (oor || !rt_ok) ? '0 : CW'(rt7);
      s1_ok    <= '{above: up_ok, below: dn_ok, left: lf_ok, right: rt_ok};
    end
  end

  lgnc_census #(.COLS(MAX_COLS)) u_census (
    .row_above(word_up), .row_mid(word_mid), .row_below(word_dn),
    .col_left(s1_left), .col_mid(s1_col), .col_right(s1_right),
    .ok(s1_ok), .count(census_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      cell_alive     <= !s1_oor && (s1_kind == lgnc_pkg::KIND_READ) && word_mid[s1_col];
      neighbor_count <= (!s1_oor && s1_kind == lgnc_pkg::KIND_CENSUS) ? census_count : '0;
      out_of_range   <= s1_oor;
    end
  end

`ifndef SYNTH
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input accepted during the clearing pass");

  a_oor_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (!cell_alive && neighbor_count == '0))
    else $error("out-of-range result carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (neighbor_count <= 4'd8))
    else $error("neighbor count above eight");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word lost before the read stage");
`endif

endmodule

// File: hdl/lgnc_row_mem.sv
// One copy of the cell grid: a row-wide memory with bit writes and a registered read.
module lgnc_row_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                    clk,
  input  logic                    clr_en,
  input  logic [$clog2(ROWS)-1:0] clr_row,
  input  logic                    wr_en,
  input  logic [$clog2(ROWS)-1:0] wr_row,
  input  logic [$clog2(COLS)-1:0] wr_col,
  input  logic                    wr_bit,
  input  logic                    rd_en,
  input  logic [$clog2(ROWS)-1:0] rd_row,
  output logic [COLS-1:0]         rd_data
);

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_row] <= '0;
    end else if (wr_en) begin
      mem[wr_row][wr_col] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

// File: hdl/lgnc_census.sv
// Counts the live cells among the eight neighbors from three registered row words.
module lgnc_census #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0]                 row_above,
  input  logic [COLS-1:0]                 row_mid,
  input  logic [COLS-1:0]                 row_below,
  input  logic [$clog2(COLS)-1:0]         col_left,
  input  logic [$clog2(COLS)-1:0]         col_mid,
  input  logic [$clog2(COLS)-1:0]         col_right,
  input  lgnc_pkg::nbr_ok_t               ok,
  output logic [lgnc_pkg::COUNT_W-1:0]    count
);

  logic a_l, a_m, a_r, m_l, m_r, b_l, b_m, b_r;

  always_comb begin
    a_l = ok.above && ok.left  && row_above[col_left];
    a_m = ok.above &&             row_above[col_mid];
    a_r = ok.above && ok.right && row_above[col_right];
    m_l = ok.left  &&             row_mid[col_left];
    m_r = ok.right &&             row_mid[col_right];
    b_l = ok.below && ok.left  && row_below[col_left];
    b_m = ok.below &&             row_below[col_mid];
    b_r = ok.below && ok.right && row_below[col_right];
    count = lgnc_pkg::COUNT_W'(a_l) + lgnc_pkg::COUNT_W'(a_m) + lgnc_pkg::COUNT_W'(a_r)
          + lgnc_pkg::COUNT_W'(m_l) + lgnc_pkg::COUNT_W'(m_r)
          + lgnc_pkg::COUNT_W'(b_l) + lgnc_pkg::COUNT_W'(b_m) + lgnc_pkg::COUNT_W'(b_r);
  end

endmodule

// File: test/tb_life_grid_neighbor_census.sv
// Testbench for the life grid neighbor census block: directed and random words checked in order.
`timescale 1ns / 100ps

module tb_life_grid_neighbor_census;

  localparam int GRID_ROWS    = 64;
  localparam int GRID_COLS    = 64;
  localparam int DRAIN_CYCLES = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic       alive;
    logic [3:0] count;
    logic       oor;
  } census_result_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  lgnc_pkg::kind_t in_kind;
  logic [5:0]      in_row;
  logic [5:0]      in_col;
  logic            out_valid;
  logic            out_ready;
  logic            cell_alive;
  logic [3:0]      neighbor_count;
  logic            out_of_range;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [1:0]      cfg_index;
  logic [6:0]      cfg_data;

  // Shadow copy of the grid and registers, updated as words are accepted.
  logic [63:0]    grid_model [0:GRID_ROWS-1];
  logic [6:0]     rows_reg;
  logic [6:0]     cols_reg;
  logic           wrap_reg;
  census_result_t pending_results [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  bit  hold_req = 1'b0;

  life_grid_neighbor_census #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (in_kind),
    .row           (in_row),
    .col           (in_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_alive    (cell_alive),
    .neighbor_count(neighbor_count),
    .out_of_range  (out_of_range),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR: %s mismatch at cycle %0d, got %0d expected %0d",
             what, cycle_count, got, want);
    mismatch_count++;
  endtask

  function automatic int eff_dim(logic [6:0] v, int limit);
    if (v == 7'd0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic census_result_t apply_word(lgnc_pkg::kind_t k, logic [5:0] r,
                                                logic [5:0] c);
    census_result_t res;
    int nr, nc, rr, cc;
    bit take;
    nr = eff_dim(rows_reg, GRID_ROWS);
    nc = eff_dim(cols_reg, GRID_COLS);
    res = '0;
    res.oor = (int'(r) >= nr) || (int'(c) >= nc);
    if (!res.oor) begin
      case (k)
        lgnc_pkg::KIND_SET:   grid_model[r][c] = 1'b1;
        lgnc_pkg::KIND_CLEAR: grid_model[r][c] = 1'b0;
        lgnc_pkg::KIND_READ:  res.alive = grid_model[r][c];
        default: begin
          // Each of the eight positions counts on its own, even when a small
          // torus folds several of them onto the same cell.
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0) begin
                rr = int'(r) + dr;
                cc = int'(c) + dc;
                take = 1'b1;
                if (wrap_reg) begin
                  rr = (rr + nr) % nr;
                  cc = (cc + nc) % nc;
                end else if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) begin
                  take = 1'b0;
                end
                if (take) res.count = res.count + grid_model[rr][cc];
              end
            end
          end
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin : result_check
    census_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (cell_alive !== want.alive)
          report_mismatch("cell_alive", cell_alive, want.alive);
        if (neighbor_count !== want.count)
          report_mismatch("neighbor_count", neighbor_count, want.count);
        if (out_of_range !== want.oor)
          report_mismatch("out_of_range", out_of_range, want.oor);
      end
    end
  end

  // Receiver side: random stalls, a steady mode, and one long hold-off on request.
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic offer_word(lgnc_pkg::kind_t k, logic [5:0] r, logic [5:0] c);
    int gap;
    if (!tx_steady && $urandom_range(99) < 20) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_row   <= r;
    in_col   <= c;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_results.push_back(apply_word(k, r, c));
  endtask

  // Drops the input valid and lets every outstanding result word come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(logic [1:0] idx, logic [6:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      lgnc_pkg::REG_ROWS: rows_reg = data;
      lgnc_pkg::REG_COLS: cols_reg = data;
      lgnc_pkg::REG_WRAP: wrap_reg = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic lgnc_pkg::kind_t pick_kind();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return lgnc_pkg::KIND_SET;
    if (sel < 55) return lgnc_pkg::KIND_CLEAR;
    if (sel < 75) return lgnc_pkg::KIND_READ;
    return lgnc_pkg::KIND_CENSUS;
  endfunction

  // Mostly in the area in use, half clustered around a hot spot so censuses
  // see live cells; a tenth is arbitrary and may fall outside the area.
  function automatic logic [5:0] pick_coord(int dim, int hot);
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 6'($urandom_range(63));
    if (sel < 60) return 6'((hot + int'($urandom_range(0, 5)) + dim - 2) % dim);
    return 6'($urandom_range(dim - 1));
  endfunction

  task automatic send_random_words(int count);
    int nr, nc, hot_r, hot_c;
    logic [5:0] r, c;
    nr = eff_dim(rows_reg, GRID_ROWS);
    nc = eff_dim(cols_reg, GRID_COLS);
    hot_r = ($urandom_range(3) == 0) ? 0 : $urandom_range(nr - 1);
    hot_c = ($urandom_range(3) == 0) ? nc - 1 : $urandom_range(nc - 1);
    for (int i = 0; i < count; i++) begin
      r = pick_coord(nr, hot_r);
      c = pick_coord(nc, hot_c);
      offer_word(pick_kind(), r, c);
    end
  endtask

  task automatic run_phase(logic [6:0] rows, logic [6:0] cols, logic wrap, int count);
    set_register(lgnc_pkg::REG_ROWS, rows);
    set_register(lgnc_pkg::REG_COLS, cols);
    set_register(lgnc_pkg::REG_WRAP, {6'($urandom_range(63)), wrap});
    send_random_words(count);
  endtask

  task automatic test_reset_defaults();
    offer_word(lgnc_pkg::KIND_READ, 6'd63, 6'd63);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd31, 6'd31);
    offer_word(lgnc_pkg::KIND_READ, 6'd0, 6'd0);
  endtask

  task automatic test_bounded_edges();
    set_register(lgnc_pkg::REG_WRAP, 7'd0);
    offer_word(lgnc_pkg::KIND_SET, 6'd0, 6'd0);
    offer_word(lgnc_pkg::KIND_SET, 6'd0, 6'd63);
    offer_word(lgnc_pkg::KIND_SET, 6'd63, 6'd0);
    offer_word(lgnc_pkg::KIND_SET, 6'd63, 6'd63);
    offer_word(lgnc_pkg::KIND_SET, 6'd1, 6'd1);
    offer_word(lgnc_pkg::KIND_SET, 6'd62, 6'd62);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd0, 6'd0);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd63, 6'd63);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd0, 6'd63);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd1, 6'd0);
  endtask

  task automatic test_wrapped_edges();
    set_register(lgnc_pkg::REG_WRAP, 7'd1);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd0, 6'd0);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd63, 6'd63);
  endtask

  // Zero and oversized registers, an unknown index, and a tiny torus.
  task automatic test_register_limits();
    set_register(lgnc_pkg::REG_ROWS, 7'd0);
    set_register(lgnc_pkg::REG_COLS, 7'h7f);
    set_register(REG_UNUSED, 7'h55);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd0, 6'd0);
    offer_word(lgnc_pkg::KIND_READ, 6'd1, 6'd0);
    offer_word(lgnc_pkg::KIND_SET, 6'd5, 6'd5);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd63, 6'd1);
    set_register(lgnc_pkg::REG_ROWS, 7'd2);
    set_register(lgnc_pkg::REG_COLS, 7'd2);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd1, 6'd1);
    offer_word(lgnc_pkg::KIND_CLEAR, 6'd0, 6'd0);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd1, 6'd1);
    offer_word(lgnc_pkg::KIND_READ, 6'd0, 6'd2);
  endtask

  // Cells beyond a shrunk area keep their state and show again afterwards.
  task automatic test_shrunk_area();
    set_register(lgnc_pkg::REG_ROWS, 7'd64);
    set_register(lgnc_pkg::REG_COLS, 7'd64);
    set_register(lgnc_pkg::REG_WRAP, 7'd0);
    offer_word(lgnc_pkg::KIND_READ, 6'd63, 6'd63);
    offer_word(lgnc_pkg::KIND_READ, 6'd5, 6'd5);
    offer_word(lgnc_pkg::KIND_CENSUS, 6'd62, 6'd62);
  endtask

  task automatic test_random_sweep();
    run_phase(7'd64, 7'd64, 1'b0, 110);
    run_phase(7'd64, 7'd64, 1'b1, 110);
    run_phase(7'd1, 7'd1, 1'b1, 60);
    run_phase(7'd2, 7'd2, 1'b1, 80);
    run_phase(7'd2, 7'd3, 1'b0, 60);
    run_phase(7'h7f, 7'd0, 1'b1, 60);
    run_phase(7'd3, 7'd64, 1'b1, 80);
    for (int p = 0; p < 4; p++) begin
      run_phase(($urandom_range(1) != 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 12)),
                ($urandom_range(1) != 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 12)),
                1'($urandom_range(1)), 100);
    end
  endtask

  task automatic test_steady_stream();
    wait_idle();
    @(negedge clk);
    rx_steady = 1'b1;
    @(posedge clk);
    tx_steady = 1'b1;
    send_random_words(120);
    wait_idle();
    @(negedge clk);
    rx_steady = 1'b0;
    @(posedge clk);
    tx_steady = 1'b0;
  endtask

  // The receiver stops for a long stretch while words keep coming, so the
  // pipeline fills and the block must hold off its input.
  task automatic test_output_backpressure();
    set_register(lgnc_pkg::REG_ROWS, 7'd8);
    set_register(lgnc_pkg::REG_COLS, 7'd8);
    set_register(lgnc_pkg::REG_WRAP, 7'd1);
    wait_idle();
    @(negedge clk);
    hold_req = 1'b1;
    @(posedge clk);
    tx_steady = 1'b1;
    send_random_words(40);
    tx_steady = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_kind   = lgnc_pkg::KIND_SET;
    in_row    = 6'd0;
    in_col    = 6'd0;
    cfg_valid = 1'b0;
    cfg_index = lgnc_pkg::REG_ROWS;
    cfg_data  = 7'd0;
    for (int i = 0; i < GRID_ROWS; i++) grid_model[i] = '0;
    rows_reg = 7'd64;
    cols_reg = 7'd64;
    wrap_reg = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // The block clears its grid after reset and holds in_ready low meanwhile.
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);

    test_reset_defaults();
    test_bounded_edges();
    test_wrapped_edges();
    test_register_limits();
    test_shrunk_area();
    test_random_sweep();
    test_steady_stream();
    test_output_backpressure();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lgnc_pkg.sv
hdl/lgnc_row_mem.sv
hdl/lgnc_census.sv
hdl/life_grid_neighbor_census.sv
test/tb_life_grid_neighbor_census.sv
